### rtl/core/sbms_pkg.sv
// Shared package for the shared-buffer multi-stack core.
// Holds field widths, operation and status codes, FSM state and control types.
// No dependencies.
package sbms_pkg;

    localparam int MODE_W = 2;
    localparam int SID_W  = 2;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;   // latch item, launch slot memory read
        logic exec;   // apply the operation, emit the result
    } ctrl_cmd_t;

endpackage

### rtl/core/sbms_ctrl.sv
// Controller FSM for the shared-buffer multi-stack core.
// Sequences each item through a load step and an execute step.
// Depends on sbms_pkg.
module sbms_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    output sbms_pkg::ctrl_cmd_t   cmd
);

    sbms_pkg::state_t state_reg;
    sbms_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbms_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sbms_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = sbms_pkg::ST_EXEC;
                end
            end
            sbms_pkg::ST_EXEC:
            begin
                state_next = sbms_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sbms_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy     = 1'b0;
        cmd.load = 1'b0;
        cmd.exec = 1'b0;
        case (state_reg)
            sbms_pkg::ST_IDLE:
            begin
                cmd.load = start;
            end
            sbms_pkg::ST_EXEC:
            begin
                busy     = 1'b1;
                cmd.exec = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

### rtl/core/sbms_dp.sv
// Datapath for the shared-buffer multi-stack core: slot value and link memories,
// stack head registers, free-list head and fill count, result registers.
// Depends on sbms_pkg.
module sbms_dp
#(
    parameter int POOL_SLOTS  = 16,
    parameter int STACK_COUNT = 4
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  sbms_pkg::ctrl_cmd_t               cmd,
    input  logic [sbms_pkg::MODE_W-1:0]       mode,
    input  logic [sbms_pkg::SID_W-1:0]        stack_id,
    input  logic signed [sbms_pkg::DATA_W-1:0] push_value,
    output logic                              done,
    output logic signed [sbms_pkg::DATA_W-1:0] read_value,
    output logic [sbms_pkg::STAT_W-1:0]       status
);

    localparam int IDX_W  = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int PTR_W  = $clog2(POOL_SLOTS + 1);
    localparam int HSEL_W = (STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1;
    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_SLOTS);

    // slot memories
    logic [sbms_pkg::DATA_W-1:0] values_mem [POOL_SLOTS];
    logic [PTR_W-1:0]            links_mem  [POOL_SLOTS];

    // list state
    logic [PTR_W-1:0] heads_reg [STACK_COUNT];
    logic [PTR_W-1:0] free_head_reg;
    logic [PTR_W-1:0] free_head_next;
    logic [PTR_W-1:0] fill_reg;       // slots at or above this were never allocated
    logic [PTR_W-1:0] fill_next;

    // latched item
    logic [sbms_pkg::MODE_W-1:0] mode_reg;
    logic [HSEL_W-1:0]           sid_reg;
    logic                        sid_ok_reg;
    logic [sbms_pkg::DATA_W-1:0] val_reg;
    logic [PTR_W-1:0]            addr_reg;
    logic [sbms_pkg::DATA_W-1:0] val_rd_reg;
    logic [PTR_W-1:0]            link_rd_reg;

    // result
    logic                              done_reg;
    logic signed [sbms_pkg::DATA_W-1:0] result_reg;
    logic signed [sbms_pkg::DATA_W-1:0] result_next;
    logic [sbms_pkg::STAT_W-1:0]       status_reg;
    logic [sbms_pkg::STAT_W-1:0]       status_next;

    // load-side selection
    logic              sid_in_ok;
    logic [HSEL_W-1:0] sid_in;
    logic [PTR_W-1:0]  head_in;
    logic [PTR_W-1:0]  addr_in;

    // execute-side control
    logic             values_we;
    logic             links_we;
    logic [PTR_W-1:0] links_wdata;
    logic             head_we;
    logic [PTR_W-1:0] head_wdata;
    logic [PTR_W-1:0] link_eff;
    logic             untouched;

    // pick the slot to look up: free-list head for push, stack top otherwise
    always_comb
    begin
        sid_in_ok = (int'(stack_id) < STACK_COUNT);
        sid_in    = HSEL_W'(stack_id);
        head_in   = sid_in_ok ? heads_reg[sid_in] : NULL_PTR;
        addr_in   = (mode == sbms_pkg::MODE_PUSH) ? free_head_reg : head_in;
    end

    // item latch and registered memory read
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg    <= mode;
            sid_reg     <= sid_in;
            sid_ok_reg  <= sid_in_ok;
            val_reg     <= push_value;
            addr_reg    <= addr_in;
            val_rd_reg  <= values_mem[addr_in[IDX_W-1:0]];
            link_rd_reg <= links_mem[addr_in[IDX_W-1:0]];
        end
    end

    // a never-allocated slot links to the next slot, the last one to null
    always_comb
    begin
        untouched = (addr_reg >= fill_reg);
        link_eff  = untouched ? (addr_reg + PTR_W'(1)) : link_rd_reg;
    end

    // execute the operation
    always_comb
    begin
        values_we      = 1'b0;
        links_we       = 1'b0;
        links_wdata    = free_head_reg;
        head_we        = 1'b0;
        head_wdata     = addr_reg;
        free_head_next = free_head_reg;
        fill_next      = fill_reg;
        result_next    = '0;
        status_next    = sbms_pkg::STAT_DONE;
        if (cmd.exec)
        begin
            case (mode_reg)
                sbms_pkg::MODE_PUSH:
                begin
                    if (!sid_ok_reg)
                    begin
                        status_next = sbms_pkg::STAT_EMPTY;
                    end
                    else if (addr_reg == NULL_PTR)
                    begin
                        status_next = sbms_pkg::STAT_FULL;
                    end
                    else
                    begin
                        values_we      = 1'b1;
                        links_we       = 1'b1;
                        links_wdata    = heads_reg[sid_reg];
                        head_we        = 1'b1;
                        head_wdata     = addr_reg;
                        free_head_next = link_eff;
                        if (untouched)
                        begin
                            fill_next = addr_reg + PTR_W'(1);
                        end
                    end
                end
                sbms_pkg::MODE_POP:
                begin
                    if (!sid_ok_reg || addr_reg == NULL_PTR)
                    begin
                        status_next = sbms_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        result_next    = val_rd_reg;
                        links_we       = 1'b1;
                        links_wdata    = free_head_reg;
                        head_we        = 1'b1;
                        head_wdata     = link_eff;
                        free_head_next = addr_reg;
                    end
                end
                sbms_pkg::MODE_READ:
                begin
                    if (!sid_ok_reg || addr_reg == NULL_PTR)
                    begin
                        status_next = sbms_pkg::STAT_EMPTY;
                    end
                    else
                    begin
                        result_next = val_rd_reg;
                    end
                end
                default:
                begin
                    status_next = sbms_pkg::STAT_DONE;
                end
            endcase
        end
    end

    // slot memory writes
    always_ff @(posedge clk)
    begin
        if (values_we)
        begin
            values_mem[addr_reg[IDX_W-1:0]] <= val_reg;
        end
        if (links_we)
        begin
            links_mem[addr_reg[IDX_W-1:0]] <= links_wdata;
        end
    end

    // list control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STACK_COUNT; i++)
            begin
                heads_reg[i] <= NULL_PTR;
            end
            free_head_reg <= '0;
            fill_reg      <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (head_we)
            begin
                heads_reg[sid_reg] <= head_wdata;
            end
            free_head_reg <= free_head_next;
            fill_reg      <= fill_next;
            done_reg      <= cmd.exec;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            result_reg <= result_next;
            status_reg <= status_next;
        end
    end

    assign done       = done_reg;
    assign read_value = result_reg;
    assign status     = status_reg;

endmodule

### rtl/core/shared_buffer_multi_stack_core.sv
// Several stacks sharing one slot pool with a linked free list. An item is taken
// when start is high and busy is low; busy is then high during the execute step,
// and no new item is taken until it falls again. The edge that takes an item reads the slot
// memories at the free-list head (push) or the stack top (pop, read); the next
// edge applies the update. The result appears on read_value and status with done
// high for exactly one cycle, the cycle after busy; it cannot be held off, and a
// new item may be started in that same cycle. No clearing pass is needed after
// reset: never-allocated slots are tracked by a fill count.
// Depends on sbms_pkg, sbms_ctrl and sbms_dp.
module shared_buffer_multi_stack_core
#(
    parameter int POOL_SLOTS  = 16,
    parameter int STACK_COUNT = 4
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [sbms_pkg::MODE_W-1:0]        mode,
    input  logic [sbms_pkg::SID_W-1:0]         stack_id,
    input  logic signed [sbms_pkg::DATA_W-1:0] push_value,
    output logic                               done,
    output logic signed [sbms_pkg::DATA_W-1:0] read_value,
    output logic [sbms_pkg::STAT_W-1:0]        status
);

    sbms_pkg::ctrl_cmd_t cmd;

    // sequencing
    sbms_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    // storage and list update
    sbms_dp
    #(
        .POOL_SLOTS  (POOL_SLOTS),
        .STACK_COUNT (STACK_COUNT)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .mode       (mode),
        .stack_id   (stack_id),
        .push_value (push_value),
        .done       (done),
        .read_value (read_value),
        .status     (status)
    );

endmodule
